FILE: sv/cht_pkg.sv
`timescale 1ns / 1ps

package cht_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int KEY_W           = 31;
  localparam int VAL_W           = 32;
  localparam int KICK_W          = 10;
  localparam int CMD_W           = 2;
  localparam int STATUS_W        = 2;

  localparam logic [KICK_W-1:0] KICKS_RST = KICK_W'(128);

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FND  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_CHECK,
    S_KHASH,
    S_KCHECK
  } state_t;

endpackage

FILE: sv/cuckoo_hash_table_unit.sv
`timescale 1ns / 1ps
// lookup, delete and direct insert take one slot hash and one check step; power-of-two
//   depths hash by bit slicing, other depths run every slot hash through the divider
// each eviction adds one slot hash plus one check step
// one transaction at a time: the next is accepted once the last result can be issued
// reset: a clearing pass writes every row of both tables, in_ready low
module cuckoo_hash_table_unit #(
  parameter int TABLE_DEPTH = cht_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cht_pkg::CMD_W-1:0]          in_command,
  input  logic [cht_pkg::KEY_W-1:0]          in_key,
  input  logic signed [cht_pkg::VAL_W-1:0]   in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cht_pkg::STATUS_W-1:0]       out_status,
  output logic signed [cht_pkg::VAL_W-1:0]   out_read_value,
  output logic [cht_pkg::KEY_W-1:0]          out_dropped_key,
  output logic signed [cht_pkg::VAL_W-1:0]   out_dropped_value,
  input  logic                               cfg_we,
  input  logic [cht_pkg::KICK_W-1:0]         cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int KW = cht_pkg::KEY_W;
  localparam int VW = cht_pkg::VAL_W;
  localparam int NW = cht_pkg::KICK_W;
  localparam int EW = cht_pkg::ENTRY_W;

  cht_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]                 clr_cnt_r;
  logic [NW-1:0]                 max_kicks_r;
  logic [cht_pkg::CMD_W-1:0]     cmd_r;
  logic [KW-1:0]                 key_r, key_nxt;
  logic [VW-1:0]                 val_r, val_nxt;
  logic                          tbl_r, tbl_nxt;
  logic [NW-1:0]                 kicks_r, kicks_nxt;

  logic                          out_valid_r;
  logic [cht_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [VW-1:0]                 rd_r, rd_nxt;
  logic [KW-1:0]                 dk_r, dk_nxt;
  logic [VW-1:0]                 dv_r, dv_nxt;
  logic                          fin;

  logic                          hash_start;
  logic [KW-1:0]                 hash_key;
  logic                          hash_done;
  logic [AW-1:0]                 slot0, slot1;

  logic                          we0, we1;
  logic [AW-1:0]                 waddr0, waddr1;
  logic [EW-1:0]                 wdata0, wdata1;
  logic [EW-1:0]                 rdata0, rdata1;
  cht_pkg::entry_t               row0, row1, krow, new_row;

  logic                          accept;
  logic                          clr_last;
  logic [NW-1:0]                 limit;
  logic [NW-1:0]                 kicks_inc;
  logic                          hit0, hit1;
  logic                          evict0, drop0;
  logic                          kfree, kmatch, kevict, kdrop;

  assign in_ready  = (state_r == cht_pkg::S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_status        = status_r;
  assign out_read_value    = $signed(rd_r);
  assign out_dropped_key   = dk_r;
  assign out_dropped_value = $signed(dv_r);

  cht_hash #(
    .DEPTH(TABLE_DEPTH)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (hash_key),
    .done  (hash_done),
    .slot0 (slot0),
    .slot1 (slot1)
  );

  cht_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr0),
    .wdata (wdata0),
    .raddr (slot0),
    .rdata (rdata0)
  );

  cht_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr1),
    .wdata (wdata1),
    .raddr (slot1),
    .rdata (rdata1)
  );

  // decisions on the rows read back
  always_comb begin
    row0      = cht_pkg::entry_t'(rdata0);
    row1      = cht_pkg::entry_t'(rdata1);
    krow      = tbl_r ? row1 : row0;
    new_row   = '{valid: 1'b1, key: key_r, value: val_r};
    clr_last  = (clr_cnt_r == AW'(TABLE_DEPTH - 1));
    limit     = (max_kicks_r == '0) ? NW'(1) : max_kicks_r;
    kicks_inc = kicks_r + NW'(1);
    hit0      = row0.valid && (row0.key == key_r);
    hit1      = row1.valid && (row1.key == key_r);
    evict0    = (cmd_r == cht_pkg::CMD_INSERT) && !hit0 && !hit1 && row0.valid && row1.valid;
    drop0     = (limit == NW'(1));
    kfree     = !krow.valid;
    kmatch    = krow.key == key_r;
    kevict    = !kfree && !kmatch;
    kdrop     = kevict && (kicks_inc >= limit);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cht_pkg::S_CLEAR:  if (clr_last) state_nxt = cht_pkg::S_IDLE;
      cht_pkg::S_IDLE:   if (accept) state_nxt = cht_pkg::S_HASH;
      cht_pkg::S_HASH:   if (hash_done) state_nxt = cht_pkg::S_CHECK;
      cht_pkg::S_CHECK: begin
        if (evict0 && !drop0) state_nxt = cht_pkg::S_KHASH;
        else state_nxt = cht_pkg::S_IDLE;
      end
      cht_pkg::S_KHASH:  if (hash_done) state_nxt = cht_pkg::S_KCHECK;
      cht_pkg::S_KCHECK: begin
        if (kevict && !kdrop) state_nxt = cht_pkg::S_KHASH;
        else state_nxt = cht_pkg::S_IDLE;
      end
      default:           state_nxt = cht_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    hash_start = 1'b0;
    hash_key   = in_key;
    we0        = 1'b0;
    we1        = 1'b0;
    waddr0     = slot0;
    waddr1     = slot1;
    wdata0     = new_row;
    wdata1     = new_row;
    fin        = 1'b0;
    status_nxt = cht_pkg::ST_OK;
    rd_nxt     = '0;
    dk_nxt     = '0;
    dv_nxt     = '0;
    key_nxt    = key_r;
    val_nxt    = val_r;
    tbl_nxt    = tbl_r;
    kicks_nxt  = kicks_r;
    unique case (state_r)
      cht_pkg::S_CLEAR: begin
        we0    = 1'b1;
        we1    = 1'b1;
        waddr0 = clr_cnt_r;
        waddr1 = clr_cnt_r;
        wdata0 = '0;
        wdata1 = '0;
      end
      cht_pkg::S_IDLE: begin
        hash_start = accept;
        key_nxt    = in_key;
        val_nxt    = $unsigned(in_value);
        tbl_nxt    = 1'b0;
        kicks_nxt  = '0;
      end
      cht_pkg::S_CHECK: begin
        fin = 1'b1;
        case (cmd_r)
          cht_pkg::CMD_LOOKUP: begin
            if (hit0) rd_nxt = row0.value;
            else if (hit1) rd_nxt = row1.value;
            else status_nxt = cht_pkg::ST_NOT_FND;
          end
          cht_pkg::CMD_DELETE: begin
            wdata0 = {1'b0, row0.key, row0.value};
            wdata1 = {1'b0, row1.key, row1.value};
            if (hit0) we0 = 1'b1;
            else if (hit1) we1 = 1'b1;
            else status_nxt = cht_pkg::ST_NOT_FND;
          end
          cht_pkg::CMD_INSERT: begin
            if (hit0 || (!hit1 && !row0.valid)) begin
              we0 = 1'b1;
            end else if (hit1 || !row1.valid) begin
              we1 = 1'b1;
            end else begin
              // both candidates taken: push the table 0 occupant out
              we0       = 1'b1;
              key_nxt   = row0.key;
              val_nxt   = row0.value;
              tbl_nxt   = 1'b1;
              kicks_nxt = NW'(1);
              if (drop0) begin
                status_nxt = cht_pkg::ST_FULL;
                dk_nxt     = row0.key;
                dv_nxt     = row0.value;
              end else begin
                fin        = 1'b0;
                hash_start = 1'b1;
                hash_key   = row0.key;
              end
            end
          end
          default: ;
        endcase
      end
      cht_pkg::S_KCHECK: begin
        we0 = !tbl_r;
        we1 = tbl_r;
        if (kevict) begin
          key_nxt   = krow.key;
          val_nxt   = krow.value;
          tbl_nxt   = !tbl_r;
          kicks_nxt = kicks_inc;
          if (kdrop) begin
            fin        = 1'b1;
            status_nxt = cht_pkg::ST_FULL;
            dk_nxt     = krow.key;
            dv_nxt     = krow.value;
          end else begin
            hash_start = 1'b1;
            hash_key   = krow.key;
          end
        end else begin
          fin = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cht_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      max_kicks_r <= cht_pkg::KICKS_RST;
      out_valid_r <= 1'b0;
      tbl_r       <= 1'b0;
      kicks_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == cht_pkg::S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cfg_we) begin
        max_kicks_r <= cfg_wdata;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      tbl_r   <= tbl_nxt;
      kicks_r <= kicks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
    end
    key_r <= key_nxt;
    val_r <= val_nxt;
    if (fin) begin
      status_r <= status_nxt;
      rd_r     <= rd_nxt;
      dk_r     <= dk_nxt;
      dv_r     <= dv_nxt;
    end
  end

endmodule

FILE: sv/cht_ram.sv
`timescale 1ns / 1ps

module cht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/cht_hash.sv
`timescale 1ns / 1ps

module cht_hash #(
  parameter int DEPTH = cht_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cht_pkg::KEY_W-1:0]   key,
  output logic                        done,
  output logic [$clog2(DEPTH)-1:0]    slot0,
  output logic [$clog2(DEPTH)-1:0]    slot1
);

  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = cht_pkg::KEY_W;

  generate
    if ((DEPTH & (DEPTH - 1)) == 0) begin : g_pow2
      logic          done_r;
      logic [AW-1:0] slot0_r;
      logic [AW-1:0] slot1_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          slot0_r <= key[AW-1:0];
          slot1_r <= AW'(key >> AW);
        end
      end

      assign done  = done_r;
      assign slot0 = slot0_r;
      assign slot1 = slot1_r;
    end else begin : g_div
      localparam int MW = KW + 2;
      localparam int PW = KW + MW;
      localparam int SH = KW + AW;
      localparam logic [PW-1:0] ONE_SH = PW'(1) << SH;
      // ceil(2^SH / DEPTH) keeps the shifted product exact for every key
      localparam logic [MW-1:0] RECIP = MW'((ONE_SH + PW'(DEPTH - 1)) / PW'(DEPTH));
      localparam logic [MW-1:0] DIV   = MW'(DEPTH);

      logic          busy_r;
      logic [1:0]    step_r;
      logic          done_r;
      logic [KW-1:0] num_r;
      logic [KW-1:0] quo_r;
      logic [AW-1:0] slot0_r;
      logic [AW-1:0] slot1_r;
      logic [KW-1:0] mul_a;
      logic [MW-1:0] mul_b;
      logic [PW-1:0] prod;
      logic [KW-1:0] rem;

      // one shared multiplier: even steps form the quotient, odd steps the remainder
      always_comb begin
        mul_a = step_r[0] ? quo_r : num_r;
        mul_b = step_r[0] ? DIV : RECIP;
        prod  = PW'(mul_a) * PW'(mul_b);
        rem   = num_r - prod[KW-1:0];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          step_r <= '0;
          done_r <= 1'b0;
        end else begin
          done_r <= 1'b0;
          if (start) begin
            busy_r <= 1'b1;
            step_r <= '0;
          end else if (busy_r) begin
            step_r <= step_r + 2'd1;
            if (step_r == 2'd3) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end
      end

      // key / DEPTH and key mod DEPTH, then the same again on the quotient
      always_ff @(posedge clk) begin
        if (start) begin
          num_r <= key;
        end else if (busy_r) begin
          case (step_r)
            2'd0: quo_r <= KW'(prod >> SH);
            2'd1: begin
              slot0_r <= rem[AW-1:0];
              num_r   <= quo_r;
            end
            2'd2: quo_r <= KW'(prod >> SH);
            default: slot1_r <= rem[AW-1:0];
          endcase
        end
      end

      assign done  = done_r;
      assign slot0 = slot0_r;
      assign slot1 = slot1_r;
    end
  endgenerate

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int KEY_W    = cht_pkg::KEY_W;
  localparam int VAL_W    = cht_pkg::VAL_W;
  localparam int KICK_W   = cht_pkg::KICK_W;
  localparam int CMD_W    = cht_pkg::CMD_W;
  localparam int STATUS_W = cht_pkg::STATUS_W;
  localparam logic [KICK_W-1:0]   KICKS_RST  = cht_pkg::KICKS_RST;
  localparam logic [CMD_W-1:0]    CMD_LOOKUP = cht_pkg::CMD_LOOKUP;
  localparam logic [CMD_W-1:0]    CMD_INSERT = cht_pkg::CMD_INSERT;
  localparam logic [CMD_W-1:0]    CMD_DELETE = cht_pkg::CMD_DELETE;
  localparam logic [STATUS_W-1:0] ST_OK      = cht_pkg::ST_OK;
  localparam logic [STATUS_W-1:0] ST_NOT_FND = cht_pkg::ST_NOT_FND;
  localparam logic [STATUS_W-1:0] ST_FULL    = cht_pkg::ST_FULL;

  localparam int TBL_DEPTH = cht_pkg::TABLE_DEPTH_DEF;
  localparam int SLOT_W = $clog2(TBL_DEPTH);
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int N_DIR = 25;
  localparam int N_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int POOL_MAX = 48;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    read_value;
    logic [KEY_W-1:0]    dropped_key;
    logic [VAL_W-1:0]    dropped_value;
  } txn_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [KEY_W-1:0]    key;
    logic [VAL_W-1:0]    value;
    logic                typed;
    logic [STATUS_W-1:0] want_status;
    logic [VAL_W-1:0]    want_read;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_command = CMD_LOOKUP;
  logic [KEY_W-1:0]     in_key = '0;
  logic [VAL_W-1:0]     in_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [VAL_W-1:0]     out_read_value;
  logic [KEY_W-1:0]     out_dropped_key;
  logic [VAL_W-1:0]     out_dropped_value;
  logic                 cfg_we = 1'b0;
  logic [KICK_W-1:0]    cfg_wdata = '0;

  // shadow copy of both tables and the kick limit
  bit                   occ [2][TBL_DEPTH];
  logic [KEY_W-1:0]     slot_key [2][TBL_DEPTH];
  logic [VAL_W-1:0]     slot_val [2][TBL_DEPTH];
  logic [KICK_W-1:0]    kick_limit = KICKS_RST;

  txn_result_t          results_due [$];
  logic [KEY_W-1:0]     key_pool [$];
  bit                   calm = 1'b0;
  int                   n_errors = 0;
  int                   n_txn = 0;
  int                   n_full = 0;
  int                   n_found = 0;
  int                   stuck_cycles = 0;

  dir_row_t dir_rows [N_DIR] = '{
    '{CMD_LOOKUP, 31'h0,        32'h0,        1'b1, ST_NOT_FND, 32'h0},
    '{CMD_DELETE, 31'h7fffffff, 32'h0,        1'b1, ST_NOT_FND, 32'h0},
    '{CMD_UNUSED, 31'h7fffffff, 32'hffffffff, 1'b1, ST_OK,      32'h0},
    '{CMD_INSERT, 31'h0,        32'h80000000, 1'b1, ST_OK,      32'h0},
    '{CMD_LOOKUP, 31'h0,        32'h0,        1'b1, ST_OK,      32'h80000000},
    '{CMD_INSERT, 31'h0,        32'h7fffffff, 1'b1, ST_OK,      32'h0},
    '{CMD_LOOKUP, 31'h0,        32'h0,        1'b1, ST_OK,      32'h7fffffff},
    '{CMD_INSERT, 31'h7fffffff, 32'hffffffff, 1'b1, ST_OK,      32'h0},
    '{CMD_LOOKUP, 31'h7fffffff, 32'h0,        1'b1, ST_OK,      32'hffffffff},
    '{CMD_DELETE, 31'h7fffffff, 32'h0,        1'b1, ST_OK,      32'h0},
    '{CMD_LOOKUP, 31'h7fffffff, 32'h0,        1'b1, ST_NOT_FND, 32'h0},
    // 64 and 4096 share slot 0 with key 0 and land in table 1
    '{CMD_INSERT, 31'd64,       32'd1,        1'b1, ST_OK,      32'h0},
    '{CMD_INSERT, 31'd4096,     32'd2,        1'b1, ST_OK,      32'h0},
    '{CMD_LOOKUP, 31'd64,       32'h0,        1'b1, ST_OK,      32'd1},
    '{CMD_INSERT, 31'd64,       32'd3,        1'b1, ST_OK,      32'h0},
    '{CMD_LOOKUP, 31'd64,       32'h0,        1'b1, ST_OK,      32'd3},
    '{CMD_DELETE, 31'd64,       32'h0,        1'b1, ST_OK,      32'h0},
    '{CMD_LOOKUP, 31'd64,       32'h0,        1'b1, ST_NOT_FND, 32'h0},
    // three keys fighting over two slots run into the kick limit
    '{CMD_INSERT, 31'd8192,     32'd5,        1'b0, ST_OK,      32'h0},
    '{CMD_LOOKUP, 31'd8192,     32'h0,        1'b0, ST_OK,      32'h0},
    '{CMD_LOOKUP, 31'd0,        32'h0,        1'b0, ST_OK,      32'h0},
    '{CMD_INSERT, 31'd8256,     32'd6,        1'b0, ST_OK,      32'h0},
    '{CMD_INSERT, 31'd12352,    32'd7,        1'b0, ST_OK,      32'h0},
    '{CMD_DELETE, 31'd4096,     32'h0,        1'b0, ST_OK,      32'h0},
    '{CMD_LOOKUP, 31'd12352,    32'h0,        1'b0, ST_OK,      32'h0}
  };

  logic [KICK_W-1:0] kick_plan [N_PHASES] = '{10'd0, 10'd1, 10'd1023, 10'd0, 10'd2, 10'd128};
  int spread_plan [N_PHASES] = '{2, 1, 2, 3, 6, 2};

  cuckoo_hash_table_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_key            (in_key),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .out_dropped_key   (out_dropped_key),
    .out_dropped_value (out_dropped_value),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic logic [SLOT_W-1:0] slot_for(logic [KEY_W-1:0] k, bit side);
    return side ? SLOT_W'((k / TBL_DEPTH) % TBL_DEPTH) : SLOT_W'(k % TBL_DEPTH);
  endfunction

  // applies one transaction to the shadow tables and returns its result
  function automatic txn_result_t apply_to_tables(logic [CMD_W-1:0] cmd,
                                                  logic [KEY_W-1:0] key,
                                                  logic [VAL_W-1:0] val);
    txn_result_t      r;
    logic [SLOT_W-1:0] s0, s1, s;
    logic [KEY_W-1:0] ck, ok;
    logic [VAL_W-1:0] cv, ov;
    bit               hit0, hit1, side, done;
    int unsigned      lim, kicks;
    r = '0;
    s0 = slot_for(key, 1'b0);
    s1 = slot_for(key, 1'b1);
    hit0 = occ[0][s0] && slot_key[0][s0] == key;
    hit1 = occ[1][s1] && slot_key[1][s1] == key;
    case (cmd)
      CMD_LOOKUP: begin
        if (hit0) r.read_value = slot_val[0][s0];
        else if (hit1) r.read_value = slot_val[1][s1];
        else r.status = ST_NOT_FND;
      end
      CMD_DELETE: begin
        if (hit0) occ[0][s0] = 1'b0;
        else if (hit1) occ[1][s1] = 1'b0;
        else r.status = ST_NOT_FND;
      end
      CMD_INSERT: begin
        if (hit0) begin
          slot_val[0][s0] = val;
        end else if (hit1) begin
          slot_val[1][s1] = val;
        end else if (!occ[0][s0]) begin
          occ[0][s0] = 1'b1;
          slot_key[0][s0] = key;
          slot_val[0][s0] = val;
        end else if (!occ[1][s1]) begin
          occ[1][s1] = 1'b1;
          slot_key[1][s1] = key;
          slot_val[1][s1] = val;
        end else begin
          lim = (kick_limit == '0) ? 1 : int'(kick_limit);
          kicks = 0;
          ck = key;
          cv = val;
          side = 1'b0;
          done = 1'b0;
          while (!done) begin
            s = slot_for(ck, side);
            if (!occ[side][s]) begin
              occ[side][s] = 1'b1;
              slot_key[side][s] = ck;
              slot_val[side][s] = cv;
              done = 1'b1;
            end else if (slot_key[side][s] == ck) begin
              slot_val[side][s] = cv;
              done = 1'b1;
            end else begin
              ok = slot_key[side][s];
              ov = slot_val[side][s];
              slot_key[side][s] = ck;
              slot_val[side][s] = cv;
              kicks++;
              ck = ok;
              cv = ov;
              if (kicks >= lim) begin
                // last pair pushed out leaves the table
                r.status = ST_FULL;
                r.dropped_key = ck;
                r.dropped_value = cv;
                done = 1'b1;
              end
              side = ~side;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(int spread);
    logic [KEY_W-1:0] k;
    int unsigned      mask;
    k = KEY_W'($urandom);
    mask = (1 << spread) - 1;
    if (key_pool.size() != 0 && $urandom_range(0, 1) == 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    // crowd the keys into a few slots so evictions happen often
    if ($urandom_range(0, 9) != 0) begin
      k[SLOT_W-1:0] = SLOT_W'($urandom & mask);
      k[2*SLOT_W-1:SLOT_W] = SLOT_W'($urandom & mask);
    end
    return k;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_txn(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                          logic [VAL_W-1:0] val, bit hold, bit typed,
                          txn_result_t typed_result);
    int          gap;
    txn_result_t got;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (hold || gap != 0) begin
      in_valid <= 1'b0;
      @(negedge clk);
      repeat ((gap > 0) ? gap - 1 : 0) @(negedge clk);
      while (hold && results_due.size() != 0) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_key <= key;
    in_value <= val;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    got = apply_to_tables(cmd, key, val);
    results_due.push_back(typed ? typed_result : got);
    n_txn++;
    if (got.status == ST_FULL) n_full++;
    if (cmd == CMD_LOOKUP && got.status == ST_OK) n_found++;
    if (cmd == CMD_INSERT && got.status == ST_OK) begin
      key_pool.push_back(key);
      if (key_pool.size() > POOL_MAX) void'(key_pool.pop_front());
    end
    @(negedge clk);
  endtask

  task automatic wait_until_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_kick_limit(logic [KICK_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    kick_limit = v;
  endtask

  task automatic check_result();
    txn_result_t want;
    if (results_due.size() == 0) begin
      $error("result with nothing expected: status %0d", out_status);
      n_errors++;
      return;
    end
    want = results_due.pop_front();
    if (out_status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, out_status);
      n_errors++;
    end
    if (out_read_value !== want.read_value) begin
      $error("read_value: expected %h, got %h", want.read_value, out_read_value);
      n_errors++;
    end
    if (out_dropped_key !== want.dropped_key) begin
      $error("dropped_key: expected %h, got %h", want.dropped_key, out_dropped_key);
      n_errors++;
    end
    if (out_dropped_value !== want.dropped_value) begin
      $error("dropped_value: expected %h, got %h", want.dropped_value, out_dropped_value);
      n_errors++;
    end
  endtask

  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      check_result();
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_CYCLES) begin
      $display("cuckoo_hash_table_unit: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    txn_result_t      typed_result;
    logic [CMD_W-1:0] cmd;
    int               pick;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed transactions, reset kick limit
    for (int i = 0; i < N_DIR; i++) begin
      typed_result = '0;
      typed_result.status = dir_rows[i].want_status;
      typed_result.read_value = dir_rows[i].want_read;
      send_txn(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].value, 1'b0,
               dir_rows[i].typed, typed_result);
    end

    kick_plan[3] = KICK_W'($urandom_range(3, 1022));
    for (int p = 0; p < N_PHASES; p++) begin
      wait_until_idle();
      write_kick_limit(kick_plan[p]);
      calm = (p == 4);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) cmd = CMD_INSERT;
        else if (pick < 14) cmd = CMD_LOOKUP;
        else if (pick < 19) cmd = CMD_DELETE;
        else cmd = CMD_UNUSED;
        send_txn(cmd, pick_key(spread_plan[p]), VAL_W'($urandom),
                 $urandom_range(0, 39) == 0, 1'b0, '0);
      end
    end

    calm = 1'b0;
    wait_until_idle();
    repeat (20) @(negedge clk);
    $display("ran %0d transactions over %0d kick limit settings (128, 0, 1, 1023, %0d, 2, 128)",
             n_txn, N_PHASES + 1, kick_plan[3]);
    $display("%0d inserts hit the kick limit, %0d lookups found their key",
             n_full, n_found);
    if (n_errors == 0) begin
      $display("cuckoo_hash_table_unit: match");
    end else begin
      $display("cuckoo_hash_table_unit: mismatch");
    end
    $finish;
  end

endmodule
